// File: hdl/sliding_window_maximum_macros.svh
// ---------------------------------------------------------------------------
// Sliding window maximum assertion macros
// Concurrent check shorthands, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWM_ASSERT_NOW(label, ante, cons, msg)
`define SWM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/swm_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window maximum package
// Shared widths, types and helpers for the window maximum chain
// ---------------------------------------------------------------------------
package swm_pkg;

	// built window depth, at least two
	localparam int WINDOW_MAX = 64;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = 7;
	localparam int SAMPLE_W   = 32;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [IDX_W-1:0]           idx_t;

	// control broadcast along the cell chain
	typedef struct packed {
		logic shift;
		logic restart;
	} swm_ctl_t;

	// zero length acts as one, lengths above the built depth clamp
	function automatic len_t eff_len(input len_t len);
		len_t k;
		k = len;
		if (k == '0) begin
			k = len_t'(1);
		end else if (k > len_t'(WINDOW_MAX)) begin
			k = len_t'(WINDOW_MAX);
		end
		return k;
	endfunction

endpackage

// File: hdl/swm_if.sv
// ---------------------------------------------------------------------------
// Sliding window maximum channels
// Valid/ready channels for samples, results and the window length register
// ---------------------------------------------------------------------------

// sample channel
interface swm_in_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    sample;
	logic                  first;
	modport source (output valid, sample, first, input ready);
	modport sink   (input valid, sample, first, output ready);
endinterface

// result channel
interface swm_out_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    window_max;
	modport source (output valid, window_max, input ready);
	modport sink   (input valid, window_max, output ready);
endinterface

// window length write channel
interface swm_cfg_if;
	logic                  valid;
	logic                  ready;
	logic [6:0]            window_length;
	modport source (output valid, window_length, input ready);
	modport sink   (input valid, window_length, output ready);
endinterface

// File: hdl/sliding_window_maximum.sv
// A result is presented in the cycle after the transfer of the sample that causes it.
// Throughput: one sample per cycle while no held result waits on results.ready, set by the single compare in each cell.
// Cell i holds the maximum of the last i+1 samples; the result taps cell (effective window length)-2.
// Reset: window length returns to 1, the chain counts as empty, sample count clears.
// No clearing pass; samples are accepted from the first cycle after reset.
// ---------------------------------------------------------------------------
// Sliding window maximum
// Streaming maximum over the last window_length signed samples
// ---------------------------------------------------------------------------
`include "sliding_window_maximum_macros.svh"

module sliding_window_maximum import swm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	swm_in_if.sink    samples,
	swm_out_if.source results,
	swm_cfg_if.sink   cfg
);

	localparam int CELLS = WINDOW_MAX - 1;

	len_t     window_length_q;
	len_t     seen_q;
	logic     primed_q;
	logic     out_valid_q;
	sample_t  window_max_q;

	logic     accept;
	len_t     k_eff;
	len_t     seen_base;
	len_t     seen_next;
	logic     emit;
	idx_t     tap_idx;
	sample_t  tap;
	sample_t  new_max;
	swm_ctl_t ctl;
	sample_t  cell_max [CELLS];

	// window length register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= len_t'(1);
		end else if (cfg.valid) begin
			window_length_q <= cfg.window_length;
		end
	end

	// handshake and chain control
	assign samples.ready = !out_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;
	assign k_eff         = eff_len(window_length_q);
	assign ctl.shift     = accept;
	assign ctl.restart   = samples.first || !primed_q;

	// cell chain, cell 0 fed by the sample itself
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			swm_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.sample  (samples.sample),
				.prev    (samples.sample),
				.run_max (cell_max[i])
			);
		end else begin : g_body
			swm_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.sample  (samples.sample),
				.prev    (cell_max[i-1]),
				.run_max (cell_max[i])
			);
		end
	end

	// sample count and result value
	always_comb begin
		seen_base = samples.first ? '0 : seen_q;
		seen_next = (seen_base < k_eff) ? seen_base + len_t'(1) : seen_base;
		emit      = (seen_next >= k_eff);
		tap_idx   = idx_t'(k_eff - len_t'(2));
		tap       = cell_max[tap_idx];
		if (ctl.restart || (k_eff == len_t'(1)) || (tap < samples.sample)) begin
			new_max = samples.sample;
		end else begin
			new_max = tap;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				seen_q      <= seen_next;
				primed_q    <= 1'b1;
				out_valid_q <= emit;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			window_max_q <= new_max;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.window_max = window_max_q;

	// checks
	`SWM_ASSERT_NEXT(a_first_restarts_count, accept && samples.first, seen_q == len_t'(1), "first sample did not restart the count")
	`SWM_ASSERT_NOW(a_result_needs_samples, out_valid_q, primed_q && (seen_q != '0), "result shown with no samples seen")
	`SWM_ASSERT_NOW(a_stall_only_on_result, !samples.ready, out_valid_q && !results.ready, "input stalled without a waiting result")

endmodule

// File: hdl/swm_cell.sv
// ---------------------------------------------------------------------------
// Sliding window maximum cell
// Holds the maximum of the last (position + 1) samples of the sequence
// ---------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
	input  logic     clk,
	input  swm_ctl_t ctl,
	input  sample_t  sample,
	input  sample_t  prev,
	output sample_t  run_max
);

	sample_t run_max_q;

	// take the neighbor's running max extended by the new sample
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (ctl.restart || (prev < sample)) begin
				run_max_q <= sample;
			end else begin
				run_max_q <= prev;
			end
		end
	end

	assign run_max = run_max_q;

endmodule
